[rtl/core/kpac_pkg.sv]
// ----------------------------------------------------------------------------
// kpac_pkg
// Types, codes and digit helpers shared by the keypad-set alarm clock and
// its port checker.
// ----------------------------------------------------------------------------
package kpac_pkg;

  localparam logic [3:0] NO_DIGIT     = 4'hF;
  localparam logic [1:0] KEY_A_ROW    = 2'd0;
  localparam logic [1:0] KEY_A_COL    = 2'd3;
  localparam logic [7:0] TPM_RESET    = 8'd240;

  localparam logic [1:0] PHASE_WAIT   = 2'd0;
  localparam logic [1:0] PHASE_TIME   = 2'd1;
  localparam logic [1:0] PHASE_ALARM  = 2'd2;
  localparam logic [1:0] PHASE_RUN    = 2'd3;

  localparam logic [1:0] POS_HOUR_TENS   = 2'd0;
  localparam logic [1:0] POS_HOUR_ONES   = 2'd1;
  localparam logic [1:0] POS_MINUTE_TENS = 2'd2;
  localparam logic [1:0] POS_MINUTE_ONES = 2'd3;

  localparam logic       REG_TICKS_PER_MINUTE = 1'b0;

  typedef enum logic [3:0] {
    MODE_WAIT  = 4'b0001,
    MODE_TIME  = 4'b0010,
    MODE_ALARM = 4'b0100,
    MODE_RUN   = 4'b1000
  } mode_t;

  typedef struct packed {
    logic       op;
    logic [1:0] key_row;
    logic [1:0] key_col;
  } in_t;

  typedef struct packed {
    logic [1:0] phase;
    logic       key_accepted;
    logic [1:0] entry_position;
    logic [1:0] hour_tens;
    logic [3:0] hour_ones;
    logic [2:0] minute_tens;
    logic [3:0] minute_ones;
    logic       minute_advanced;
    logic       alarm_on;
  } out_t;

  typedef struct packed {
    logic [1:0] hour_tens;
    logic [3:0] hour_ones;
    logic [2:0] minute_tens;
    logic [3:0] minute_ones;
  } clock_time_t;

  function automatic logic [3:0] key_digit(input logic [3:0] key);
    logic [3:0] d;
    case (key)
      4'd0:    d = 4'd1;
      4'd1:    d = 4'd2;
      4'd2:    d = 4'd3;
      4'd4:    d = 4'd4;
      4'd5:    d = 4'd5;
      4'd6:    d = 4'd6;
      4'd8:    d = 4'd7;
      4'd9:    d = 4'd8;
      4'd10:   d = 4'd9;
      4'd13:   d = 4'd0;
      default: d = NO_DIGIT;
    endcase
    return d;
  endfunction

  function automatic logic digit_ok(input logic [1:0] pos, input logic [3:0] d,
                                    input logic [1:0] tens);
    logic ok;
    if (d > 4'd9) begin
      ok = 1'b0;
    end else begin
      case (pos)
        POS_HOUR_TENS:   ok = (d <= 4'd2);
        POS_HOUR_ONES:   ok = (tens == 2'd2) ? (d <= 4'd3) : 1'b1;
        POS_MINUTE_TENS: ok = (d <= 4'd5);
        default:         ok = 1'b1;
      endcase
    end
    return ok;
  endfunction

  function automatic clock_time_t store_digit(input clock_time_t t, input logic [1:0] pos,
                                              input logic [3:0] d);
    clock_time_t r;
    r = t;
    case (pos)
      POS_HOUR_TENS:   r.hour_tens   = d[1:0];
      POS_HOUR_ONES:   r.hour_ones   = d;
      POS_MINUTE_TENS: r.minute_tens = d[2:0];
      default:         r.minute_ones = d;
    endcase
    return r;
  endfunction

  function automatic clock_time_t advance_minute(input clock_time_t t);
    clock_time_t r;
    r = t;
    if (t.minute_ones < 4'd9) begin
      r.minute_ones = t.minute_ones + 4'd1;
    end else begin
      r.minute_ones = 4'd0;
      if (t.minute_tens < 3'd5) begin
        r.minute_tens = t.minute_tens + 3'd1;
      end else begin
        r.minute_tens = 3'd0;
        if (t.hour_tens >= 2'd2) begin
          if (t.hour_ones >= 4'd3) begin
            r.hour_ones = 4'd0;
            r.hour_tens = 2'd0;
          end else begin
            r.hour_ones = t.hour_ones + 4'd1;
          end
        end else if (t.hour_ones < 4'd9) begin
          r.hour_ones = t.hour_ones + 4'd1;
        end else begin
          r.hour_ones = 4'd0;
          r.hour_tens = t.hour_tens + 2'd1;
        end
      end
    end
    return r;
  endfunction

endpackage

[rtl/core/keypad_set_alarm_clock.sv]
// ----------------------------------------------------------------------------
// keypad_set_alarm_clock
// 24-hour BCD alarm clock set from decoded keypad presses, run by ticks.
// ----------------------------------------------------------------------------
// Each request (a key press or a prescaler tick) yields exactly one result.
// A request is taken when in_valid and in_ready are both high; its result is
// registered into the output register, or into a second result buffer behind
// it while a result waits on the output side. That buffer keeps the input side
// open for one more request; a new request can be taken every cycle while it is empty.
// ticks_per_minute sits at byte address 0 of the APB port.
module keypad_set_alarm_clock
  import kpac_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]  ticks_per_minute;
  mode_t       mode, mode_next;
  logic [1:0]  digit_index, digit_index_next;
  clock_time_t time_digits, time_digits_next;
  clock_time_t alarm_digits, alarm_digits_next;
  logic [7:0]  tick_count, tick_count_next;
  logic        alarm_latch, alarm_latch_next;
  out_t        result;
  out_t        skid;
  logic        skid_valid;
  logic        in_fire;
  logic        accepted;
  logic        advanced;
  logic [3:0]  digit;
  logic [1:0]  dst_tens;
  logic        ok;
  logic [8:0]  tick_inc;
  clock_time_t stored;
  clock_time_t advanced_time;

  assign pready   = 1'b1;
  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;
  assign prdata   = (paddr[2] == REG_TICKS_PER_MINUTE) ? {24'd0, ticks_per_minute} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_minute <= TPM_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_TICKS_PER_MINUTE) begin
      ticks_per_minute <= pwdata[7:0];
    end
  end

  always_comb begin
    mode_next         = mode;
    digit_index_next  = digit_index;
    time_digits_next  = time_digits;
    alarm_digits_next = alarm_digits;
    tick_count_next   = tick_count;
    alarm_latch_next  = alarm_latch;
    accepted          = 1'b0;
    advanced          = 1'b0;
    digit             = key_digit({in_data.key_row, in_data.key_col});
    dst_tens          = (mode == MODE_TIME) ? time_digits.hour_tens : alarm_digits.hour_tens;
    ok                = digit_ok(digit_index, digit, dst_tens);
    stored            = store_digit((mode == MODE_TIME) ? time_digits : alarm_digits,
                                    digit_index, digit);
    tick_inc          = {1'b0, tick_count} + 9'd1;
    advanced_time     = advance_minute(time_digits);

    if (!in_data.op) begin
      case (mode)
        MODE_WAIT: begin
          if (in_data.key_row == KEY_A_ROW && in_data.key_col == KEY_A_COL) begin
            mode_next        = MODE_TIME;
            digit_index_next = POS_HOUR_TENS;
          end
        end
        MODE_TIME: begin
          if (ok) begin
            accepted         = 1'b1;
            time_digits_next = stored;
            digit_index_next = digit_index + 2'd1;
            if (digit_index == POS_MINUTE_ONES) begin
              mode_next = MODE_ALARM;
            end
          end
        end
        MODE_ALARM: begin
          if (ok) begin
            accepted          = 1'b1;
            alarm_digits_next = stored;
            digit_index_next  = digit_index + 2'd1;
            if (digit_index == POS_MINUTE_ONES) begin
              mode_next       = MODE_RUN;
              tick_count_next = 8'd0;
              if (time_digits == stored) begin
                alarm_latch_next = 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end else if (mode == MODE_RUN) begin
      if (tick_inc >= {1'b0, ticks_per_minute}) begin
        tick_count_next  = 8'd0;
        time_digits_next = advanced_time;
        advanced         = 1'b1;
        if (advanced_time == alarm_digits) begin
          alarm_latch_next = 1'b1;
        end
      end else begin
        tick_count_next = tick_inc[7:0];
      end
    end

    case (mode_next)
      MODE_TIME:  result.phase = PHASE_TIME;
      MODE_ALARM: result.phase = PHASE_ALARM;
      MODE_RUN:   result.phase = PHASE_RUN;
      default:    result.phase = PHASE_WAIT;
    endcase
    result.key_accepted    = accepted;
    result.entry_position  = (mode_next == MODE_TIME || mode_next == MODE_ALARM) ?
                             digit_index_next : 2'd0;
    result.hour_tens       = time_digits_next.hour_tens;
    result.hour_ones       = time_digits_next.hour_ones;
    result.minute_tens     = time_digits_next.minute_tens;
    result.minute_ones     = time_digits_next.minute_ones;
    result.minute_advanced = advanced;
    result.alarm_on        = alarm_latch_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_WAIT;
      digit_index  <= 2'd0;
      time_digits  <= '0;
      alarm_digits <= '0;
      tick_count   <= 8'd0;
      alarm_latch  <= 1'b0;
    end else if (in_fire) begin
      mode         <= mode_next;
      digit_index  <= digit_index_next;
      time_digits  <= time_digits_next;
      alarm_digits <= alarm_digits_next;
      tick_count   <= tick_count_next;
      alarm_latch  <= alarm_latch_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_data <= skid_valid ? skid : result;
    end else if (in_fire) begin
      skid <= result;
    end
  end

endmodule

[rtl/core/kpac_checker.sv]
// ----------------------------------------------------------------------------
// kpac_checker
// Port-level checks for the keypad-set alarm clock, bound to the top level.
// ----------------------------------------------------------------------------
module kpac_checker
  import kpac_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_advance_running: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.minute_advanced |-> out_data.phase == PHASE_RUN)
    else $error("minute advanced outside run phase");

  a_key_or_tick: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.key_accepted |->
      !out_data.minute_advanced && out_data.phase != PHASE_WAIT)
    else $error("accepted key with tick or while waiting");

  a_entry_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.phase == PHASE_WAIT || out_data.phase == PHASE_RUN) |->
      out_data.entry_position == 2'd0)
    else $error("entry position outside entry phases");

endmodule

bind keypad_set_alarm_clock kpac_checker u_kpac_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[test/keypad_set_alarm_clock_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_set_alarm_clock_test
// Self-checking bench for the keypad-set 24-hour alarm clock. A short
// directed run enters the current time and the alarm time with rejected keys
// mixed in. Random phases then feed prescaler ticks and stray keys under
// several ticks_per_minute values (1, 255, 0 and a small random one), with
// random stalls on both sides in all but the last phase. Every result is
// compared against an in-bench model of the clock.
// ----------------------------------------------------------------------------
import kpac_pkg::*;

class clock_scoreboard;
  logic [7:0]       ticks_per_minute;
  logic [1:0]       mode;
  logic [1:0]       position;
  logic [3:0][3:0]  now_digits;
  logic [3:0][3:0]  alarm_digits;
  logic [7:0]       tick_count;
  logic             alarm_latch;
  out_t             pending[$];
  int               failures;
  logic [3:0]       key_value[16] = '{
    4'd1, 4'd2, 4'd3, NO_DIGIT,
    4'd4, 4'd5, 4'd6, NO_DIGIT,
    4'd7, 4'd8, 4'd9, NO_DIGIT,
    NO_DIGIT, 4'd0, NO_DIGIT, NO_DIGIT
  };

  function new();
    ticks_per_minute = TPM_RESET;
    mode = PHASE_WAIT;
    position = POS_HOUR_TENS;
    now_digits = '0;
    alarm_digits = '0;
    tick_count = '0;
    alarm_latch = 1'b0;
    failures = 0;
  endfunction

  function void note_failure(string msg);
    failures++;
    if (failures <= 10) begin
      $display("ERROR: %s", msg);
    end
  endfunction

  function bit digit_allowed(logic [1:0] pos, logic [3:0] d, logic [3:0] tens);
    if (d > 4'd9) return 1'b0;
    case (pos)
      POS_HOUR_TENS:   return d <= 4'd2;
      POS_HOUR_ONES:   return (tens != 4'd2) || (d <= 4'd3);
      POS_MINUTE_TENS: return d <= 4'd5;
      default:         return 1'b1;
    endcase
  endfunction

  function void step_minute();
    if (now_digits[3] < 4'd9) begin
      now_digits[3] = now_digits[3] + 4'd1;
    end else begin
      now_digits[3] = 4'd0;
      if (now_digits[2] < 4'd5) begin
        now_digits[2] = now_digits[2] + 4'd1;
      end else begin
        now_digits[2] = 4'd0;
        if (now_digits[0] >= 4'd2) begin
          if (now_digits[1] >= 4'd3) begin
            now_digits[1] = 4'd0;
            now_digits[0] = 4'd0;
          end else begin
            now_digits[1] = now_digits[1] + 4'd1;
          end
        end else if (now_digits[1] < 4'd9) begin
          now_digits[1] = now_digits[1] + 4'd1;
        end else begin
          now_digits[1] = 4'd0;
          now_digits[0] = now_digits[0] + 4'd1;
        end
      end
    end
  endfunction

  function void note_request(in_t req);
    out_t       r;
    logic [3:0] d;
    logic [3:0] tens;
    logic [8:0] next_count;
    r = '0;
    if (!req.op) begin
      if (mode == PHASE_WAIT) begin
        if (req.key_row == KEY_A_ROW && req.key_col == KEY_A_COL) begin
          mode = PHASE_TIME;
          position = POS_HOUR_TENS;
        end
      end else if (mode != PHASE_RUN) begin
        d = key_value[{req.key_row, req.key_col}];
        tens = (mode == PHASE_TIME) ? now_digits[0] : alarm_digits[0];
        if (digit_allowed(position, d, tens)) begin
          if (mode == PHASE_TIME) now_digits[position] = d;
          else alarm_digits[position] = d;
          r.key_accepted = 1'b1;
          if (position == POS_MINUTE_ONES) begin
            position = POS_HOUR_TENS;
            if (mode == PHASE_TIME) begin
              mode = PHASE_ALARM;
            end else begin
              mode = PHASE_RUN;
              tick_count = '0;
              if (now_digits == alarm_digits) alarm_latch = 1'b1;
            end
          end else begin
            position = position + 2'd1;
          end
        end
      end
    end else if (mode == PHASE_RUN) begin
      next_count = {1'b0, tick_count} + 9'd1;
      if (next_count >= {1'b0, ticks_per_minute}) begin
        tick_count = '0;
        step_minute();
        r.minute_advanced = 1'b1;
        if (now_digits == alarm_digits) alarm_latch = 1'b1;
      end else begin
        tick_count = next_count[7:0];
      end
    end
    r.phase = mode;
    r.entry_position = (mode == PHASE_TIME || mode == PHASE_ALARM) ? position : 2'd0;
    r.hour_tens = now_digits[0][1:0];
    r.hour_ones = now_digits[1];
    r.minute_tens = now_digits[2][2:0];
    r.minute_ones = now_digits[3];
    r.alarm_on = alarm_latch;
    pending.push_back(r);
  endfunction

  function string show(out_t v);
    return $sformatf("phase=%0d acc=%0d pos=%0d time=%0d%0d:%0d%0d adv=%0d alarm=%0d",
                     v.phase, v.key_accepted, v.entry_position, v.hour_tens, v.hour_ones,
                     v.minute_tens, v.minute_ones, v.minute_advanced, v.alarm_on);
  endfunction

  function void check_display(out_t got);
    out_t want;
    if (pending.size() == 0) begin
      note_failure($sformatf("unexpected result %s", show(got)));
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      note_failure($sformatf("expected %s, got %s", show(want), show(got)));
    end
  endfunction
endclass

module keypad_set_alarm_clock_test;

  localparam int         LIMIT    = 300000;
  localparam logic [2:0] TPM_ADDR = {REG_TICKS_PER_MINUTE, 2'b00};

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  in_t         in_data   = '0;
  logic        out_ready = 1'b0;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic        in_ready;
  logic        out_valid;
  out_t        out_data;
  logic [31:0] prdata;
  logic        pready;

  int send_idle_pct = 24;
  int recv_idle_pct = 76;
  int hold_reqs     = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int cycles        = 0;

  clock_scoreboard sb = new();

  keypad_set_alarm_clock i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_display(out_data);
    end
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= 150;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_req(input in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(req);
  endtask

  task automatic press(input logic [1:0] row, input logic [1:0] col);
    in_t req;
    req.op = 1'b0;
    req.key_row = row;
    req.key_col = col;
    send_req(req);
  endtask

  task automatic tick_req();
    in_t req;
    req.op = 1'b1;
    req.key_row = 2'($urandom);
    req.key_col = 2'($urandom);
    send_req(req);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_ticks_per_minute(input logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= TPM_ADDR;
    pwdata <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.ticks_per_minute = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[7:0] !== value) begin
      sb.note_failure($sformatf("ticks_per_minute read %0d, wrote %0d", prdata[7:0], value));
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_phase(input logic [7:0] tpm, input int ticks, input int send_pct,
                           input int recv_pct, input bit hold);
    drain();
    write_ticks_per_minute(tpm);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    if (hold) hold_reqs++;
    for (int i = 0; i < ticks; i++) begin
      if ($urandom_range(99) < 12) press(2'($urandom), 2'($urandom));
      tick_req();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    write_ticks_per_minute(8'd1);

    tick_req();
    press(2'd0, 2'd0);
    press(2'd3, 2'd3);
    press(KEY_A_ROW, KEY_A_COL);
    tick_req();
    press(2'd0, 2'd2);
    press(KEY_A_ROW, KEY_A_COL);
    press(2'd0, 2'd1);
    press(2'd1, 2'd0);
    press(2'd0, 2'd2);
    press(2'd1, 2'd2);
    press(2'd1, 2'd1);
    press(2'd3, 2'd0);
    press(2'd2, 2'd2);
    press(2'd3, 2'd1);
    press(2'd2, 2'd2);
    press(2'd2, 2'd0);
    press(2'd3, 2'd1);
    press(2'd3, 2'd2);
    press(2'd1, 2'd3);
    press(2'd3, 2'd1);
    press(2'd2, 2'd1);
    tick_req();
    tick_req();

    run_phase(8'd1, 600, 24, 76, 1'b0);
    run_phase(8'd255, 300, 76, 24, 1'b1);
    run_phase(8'd0, 250, 76, 24, 1'b0);
    run_phase(8'($urandom_range(4, 2)), 300, 0, 0, 1'b0);

    drain();
    if (sb.failures == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/kpac_pkg.sv
rtl/core/keypad_set_alarm_clock.sv
rtl/core/kpac_checker.sv
test/keypad_set_alarm_clock_test.sv
